>>> src/pcx_pkg.sv
package pcx_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 6;
  localparam int unsigned ImageW = 32;
  // Entries in the command queue between the front and back ends.
  localparam int unsigned QueueDepth = 2;

  // A byte at or above this value is a run marker in run-length mode.
  localparam logic [ByteW-1:0]  MARKER_MIN = 8'hC0;
  // Low bits of a marker that carry the repeat count.
  localparam logic [ByteW-1:0]  COUNT_MASK = 8'h3F;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_BYTES = 1'b0,
    REG_RLE_ENABLE  = 1'b1
  } pcx_reg_t;

  // One decode command: repeat a byte count times, and flag the final copy
  // when the command completes the image.
  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] count;
    logic              ends_image;
  } pcx_cmd_t;

  // Handshake between the command queue and the back end.
  typedef struct packed {
    logic     valid;
    pcx_cmd_t cmd;
  } pcx_q_out_t;

endpackage

>>> src/pcx_in_if.sv
interface pcx_in_if;
  logic                     valid;
  logic                     ready;
  logic [pcx_pkg::ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

>>> src/pcx_out_if.sv
interface pcx_out_if;
  logic                     valid;
  logic                     ready;
  logic [pcx_pkg::ByteW-1:0] out_byte;
  logic                     out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

>>> src/pcx_cfg_if.sv
interface pcx_cfg_if;
  logic                      valid;
  logic                      ready;
  pcx_pkg::pcx_reg_t         index;
  logic [pcx_pkg::ImageW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/pcx_front.sv
module pcx_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [pcx_pkg::ImageW-1:0] image_bytes,
  input  logic                       rle_enable,
  input  logic                       in_valid,
  input  logic [pcx_pkg::ByteW-1:0]  in_byte,
  output logic                       in_ready,
  input  logic                       q_full,
  output logic                       push,
  output pcx_pkg::pcx_cmd_t          cmd
);

  logic                        pending_r, pending_nxt;
  logic [pcx_pkg::CountW-1:0]  run_r, run_nxt;
  logic [pcx_pkg::ImageW-1:0]  emit_cnt_r, emit_cnt_nxt;

  logic                        accept;
  logic                        done;
  logic [pcx_pkg::ImageW-1:0]  remaining;
  logic [pcx_pkg::ImageW-1:0]  run_wide;
  logic [pcx_pkg::CountW-1:0]  cnt;
  logic [pcx_pkg::ByteW-1:0]   masked;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign done      = (emit_cnt_r >= image_bytes);
  assign remaining = image_bytes - emit_cnt_r;
  assign run_wide  = {{(pcx_pkg::ImageW-pcx_pkg::CountW){1'b0}}, run_r};
  assign masked    = in_byte & pcx_pkg::COUNT_MASK;

  always_comb begin
    pending_nxt = pending_r;
    run_nxt     = run_r;
    cnt         = '0;
    if (accept && !done) begin
      if (!rle_enable) begin
        pending_nxt = 1'b0;
        run_nxt     = '0;
        cnt         = pcx_pkg::CountW'(1);
      end else if (pending_r) begin
        pending_nxt = 1'b0;
        run_nxt     = '0;
        // Clip the run to the bytes still missing from the image.
        if (run_wide > remaining) begin
          cnt = remaining[pcx_pkg::CountW-1:0];
        end else begin
          cnt = run_r;
        end
      end else if (in_byte >= pcx_pkg::MARKER_MIN) begin
        pending_nxt = 1'b1;
        run_nxt     = masked[pcx_pkg::CountW-1:0];
      end else begin
        cnt = pcx_pkg::CountW'(1);
      end
    end
  end

  assign push           = (cnt != '0);
  assign cmd.data       = in_byte;
  assign cmd.count      = cnt;
  assign cmd.ends_image = ({{(pcx_pkg::ImageW-pcx_pkg::CountW){1'b0}}, cnt} == remaining);
  assign emit_cnt_nxt   = emit_cnt_r + {{(pcx_pkg::ImageW-pcx_pkg::CountW){1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= 1'b0;
      run_r      <= '0;
      emit_cnt_r <= '0;
    end else begin
      pending_r  <= pending_nxt;
      run_r      <= run_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  // Once the image is complete the front end must neither queue work nor move.
  a_no_push_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> !push)
    else $error("command queued after image completion");

  a_count_tracks_push: assert property (@(posedge clk) disable iff (!rst_n)
    !push |=> $stable(emit_cnt_r))
    else $error("emitted count moved without a queued command");

endmodule

>>> src/pcx_queue.sv
module pcx_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pcx_pkg::pcx_cmd_t   push_cmd,
  output logic                full,
  input  logic                pop,
  output pcx_pkg::pcx_q_out_t head
);

  pcx_pkg::pcx_cmd_t mem_r [pcx_pkg::QueueDepth];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        fill_r, fill_nxt;

  assign full       = (fill_r == 2'(pcx_pkg::QueueDepth));
  assign head.valid = (fill_r != '0);
  assign head.cmd   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command queue overflow");

endmodule

>>> src/pcx_back.sv
module pcx_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pcx_pkg::pcx_q_out_t       head,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pcx_pkg::ByteW-1:0] out_byte,
  output logic                      out_last
);

  logic                       busy_r, busy_nxt;
  logic [pcx_pkg::ByteW-1:0]  byte_r, byte_nxt;
  logic [pcx_pkg::CountW-1:0] left_r, left_nxt;
  logic                       ends_r, ends_nxt;
  logic                       fire;
  logic                       final_copy;

  assign fire       = busy_r && out_ready;
  assign final_copy = (left_r == pcx_pkg::CountW'(1));
  assign pop        = head.valid && (!busy_r || (fire && final_copy));

  always_comb begin
    busy_nxt = busy_r;
    byte_nxt = byte_r;
    left_nxt = left_r;
    ends_nxt = ends_r;
    if (pop) begin
      busy_nxt = 1'b1;
      byte_nxt = head.cmd.data;
      left_nxt = head.cmd.count;
      ends_nxt = head.cmd.ends_image;
    end else if (fire) begin
      if (final_copy) begin
        busy_nxt = 1'b0;
      end else begin
        left_nxt = left_r - pcx_pkg::CountW'(1);
      end
    end
  end

  assign out_valid = busy_r;
  assign out_byte  = byte_r;
  assign out_last  = ends_r && final_copy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    ends_r <= ends_nxt;
  end

  a_busy_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (left_r != '0))
    else $error("active command with zero copies left");

endmodule

>>> src/pcx_rle_decoder_core.sv
// A literal byte is written into the command queue when its request is accepted
// and then moved into the back-end registers that drive the output. Throughput:
// literals and raw bytes go one per cycle while the output is ready; a run takes two
// input requests (marker, data) and then emits one byte per cycle from the back end.
// A two-entry command queue lets the input keep flowing while a run drains.
// Reset (rst_n low, synchronous) clears the queue, the pending marker and the
// emitted count, sets image_bytes to 0 and rle_enable to 1.
module pcx_rle_decoder_core (
  input  logic         clk,
  input  logic         rst_n,
  pcx_in_if.sink       in_chan,
  pcx_out_if.source    out_chan,
  pcx_cfg_if.sink      cfg_chan
);

  // Configuration registers. Writes are always taken; the user must issue them
  // only while the decoder is idle; the block has no interlock to enforce this.
  logic [pcx_pkg::ImageW-1:0] image_bytes_r, image_bytes_nxt;
  logic                       rle_enable_r, rle_enable_nxt;

  logic                       q_full;
  logic                       push;
  pcx_pkg::pcx_cmd_t          push_cmd;
  logic                       pop;
  pcx_pkg::pcx_q_out_t        head;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    image_bytes_nxt = image_bytes_r;
    rle_enable_nxt  = rle_enable_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.index)
        pcx_pkg::REG_IMAGE_BYTES: image_bytes_nxt = cfg_chan.data;
        pcx_pkg::REG_RLE_ENABLE:  rle_enable_nxt  = cfg_chan.data[0];
        default:                  image_bytes_nxt = image_bytes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_bytes_r <= '0;
      rle_enable_r  <= 1'b1;
    end else begin
      image_bytes_r <= image_bytes_nxt;
      rle_enable_r  <= rle_enable_nxt;
    end
  end

  // The front end classifies each request, tracks the pending run marker and
  // the running output count, and clips runs against the image size. It
  // queues one command per byte value to be emitted, with its repeat count.
  pcx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .image_bytes (image_bytes_r),
    .rle_enable  (rle_enable_r),
    .in_valid    (in_chan.valid),
    .in_byte     (in_chan.in_byte),
    .in_ready    (in_chan.ready),
    .q_full      (q_full),
    .push        (push),
    .cmd         (push_cmd)
  );

  pcx_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // The back end holds the active command in registers that drive the output
  // directly, and emits one copy per accepted output request.
  pcx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.out_last)
  );

endmodule
